### rtl/core/stable_priority_queue_unit_assert.svh
// Assertion helpers for the priority queue checks.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// a holds -> b holds in the same cycle
`define SPQ_ASSERT_IMPLY(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("spq: same-cycle check failed");

// a holds -> b holds in the next cycle
`define SPQ_ASSERT_NEXT(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("spq: next-cycle check failed");

`endif

### rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int VALUE_W = 16;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 5;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic               insert;
    logic               seed;
    logic               scan;
    logic               pick;
    logic [PRIO_W-1:0]  mask;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } spq_cmd_t;

  // reductions over the chain, back to control
  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } spq_stat_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    logic               found;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } spq_res_t;

endpackage

### rtl/core/spq_in_if.sv
interface spq_in_if
  import spq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [VALUE_W-1:0] value_in;
  logic [PRIO_W-1:0]  prio_in;

  modport source(output valid, action, value_in, prio_in, input ready);
  modport sink(input valid, action, value_in, prio_in, output ready);
endinterface

### rtl/core/spq_out_if.sv
interface spq_out_if
  import spq_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_out;
  logic [PRIO_W-1:0]  prio_out;
  logic               found;
  logic [1:0]         status;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;

  modport source(output valid, value_out, prio_out, found, status, entry_count, is_empty,
                 input ready);
  modport sink(input valid, value_out, prio_out, found, status, entry_count, is_empty,
               output ready);
endinterface

### rtl/core/spq_cell.sv
module spq_cell
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  spq_cmd_t           cmd,
  input  logic               any_hit,
  input  logic               left_valid,
  input  logic               prefix_in,
  input  logic               right_valid,
  input  logic [VALUE_W-1:0] right_value,
  input  logic [PRIO_W-1:0]  right_prio,
  output logic               valid,
  output logic [VALUE_W-1:0] value,
  output logic [PRIO_W-1:0]  prio,
  output logic               cand,
  output logic               hit,
  output logic               match,
  output logic               first
);

  logic load_ins;
  logic load_shift;

  assign load_ins   = cmd.insert && !valid && left_valid;
  // this cell is the removed one or lies behind it
  assign load_shift = cmd.pick && (prefix_in || cand);

  assign hit   = cand && (|(prio & cmd.mask));
  assign match = valid && (value == cmd.value);
  assign first = cand && !prefix_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cand  <= 1'b0;
    end else begin
      if (load_ins) begin
        valid <= 1'b1;
      end else if (load_shift) begin
        valid <= right_valid;
      end
      if (cmd.seed) begin
        cand <= valid;
      end else if (cmd.scan && any_hit) begin
        cand <= hit;
      end else if (cmd.pick) begin
        cand <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ins) begin
      value <= cmd.value;
      prio  <= cmd.prio;
    end else if (load_shift) begin
      value <= right_value;
      prio  <= right_prio;
    end
  end

endmodule

### rtl/core/spq_chain.sv
module spq_chain
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  spq_cmd_t            cmd,
  output spq_stat_t           stat,
  output logic [CAPACITY-1:0] occupied
);

  logic [VALUE_W-1:0] values [CAPACITY];
  logic [PRIO_W-1:0]  prios  [CAPACITY];
  logic [CAPACITY-1:0] cand;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] prefix;
  logic                any_hit;

  assign any_hit = |hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_valid;
    logic               right_valid;
    logic [VALUE_W-1:0] right_value;
    logic [PRIO_W-1:0]  right_prio;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign prefix[i]  = 1'b0;
    end else begin : g_body
      assign left_valid = occupied[i-1];
      // some earlier cell still holds a candidate
      assign prefix[i]  = prefix[i-1] | cand[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_inner
      assign right_valid = occupied[i+1];
      assign right_value = values[i+1];
      assign right_prio  = prios[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .any_hit    (any_hit),
      .left_valid (left_valid),
      .prefix_in  (prefix[i]),
      .right_valid(right_valid),
      .right_value(right_value),
      .right_prio (right_prio),
      .valid      (occupied[i]),
      .value      (values[i]),
      .prio       (prios[i]),
      .cand       (cand[i]),
      .hit        (hit[i]),
      .match      (match[i]),
      .first      (first[i])
    );
  end

  // first is one-hot during the pick cycle
  always_comb begin
    stat       = '0;
    stat.found = |match;
    for (int i = 0; i < CAPACITY; i++) begin
      stat.value = stat.value | (values[i] & {VALUE_W{first[i]}});
      stat.prio  = stat.prio | (prios[i] & {PRIO_W{first[i]}});
    end
  end

endmodule

### rtl/core/stable_priority_queue_unit.sv
// Stable priority queue, up to CAPACITY entries kept in arrival order.
// req channel: action (insert, remove, query), value_in, prio_in.
// rsp channel: one item per request with the removed value and priority,
// the query flag, a status code, the entry count and an empty flag.
// Insert, query and refused operations load their result into the holding
// register at accept; the next request is taken once that register has
// passed it on. Remove first scans: the cells drop candidates one
// priority bit a cycle, MSB first, then the oldest survivor leaves and
// every cell behind it takes its right neighbor's entry in one shift.
// One request is worked on at a time; a finished result waits in a
// holding register and then the output register, so a stalled receiver
// holds back at most one further request.
// Reset clears the valid bits of all cells, the count and both result
// stages; no clearing pass is needed.
`include "stable_priority_queue_unit_assert.svh"

module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst,
  spq_in_if.sink     req,
  spq_out_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [PRIO_W-1:0]   scan_mask;
  spq_res_t            res;
  spq_res_t            res_next;
  logic                res_pending;
  logic                res_load;
  spq_res_t            out_res;
  logic                out_valid;
  logic                out_free;
  logic                accept;
  logic                full;
  spq_cmd_t            cmd;
  spq_stat_t           stat;
  logic [CAPACITY-1:0] occupied;
  logic [CW+COUNT_W-1:0] count_ext;

  assign req.ready = (state == ST_IDLE) && !res_pending;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(CAPACITY));
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    cmd        = '0;
    cmd.insert = accept && (req.action == ACT_INSERT) && !full;
    cmd.seed   = accept && (req.action == ACT_REMOVE) && (count != '0);
    cmd.scan   = (state == ST_SCAN);
    cmd.pick   = (state == ST_PICK);
    cmd.mask   = scan_mask;
    cmd.value  = req.value_in;
    cmd.prio   = req.prio_in;
  end

  spq_chain #(
    .CAPACITY(CAPACITY)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .occupied(occupied)
  );

  always_comb begin
    res_load   = 1'b0;
    res_next   = '0;
    count_next = count;
    if (state == ST_PICK) begin
      res_load       = 1'b1;
      count_next     = count - CW'(1);
      res_next.value = stat.value;
      res_next.prio  = stat.prio;
    end else if (accept && !cmd.seed) begin
      res_load = 1'b1;
      unique case (req.action)
        ACT_INSERT: begin
          if (full) begin
            res_next.status = STATUS_FULL;
          end else begin
            count_next = count + CW'(1);
          end
        end
        ACT_REMOVE: res_next.status = STATUS_EMPTY;
        ACT_QUERY:  res_next.found = stat.found;
        default: ;
      endcase
    end
    count_ext      = {{COUNT_W{1'b0}}, count_next};
    res_next.count = count_ext[COUNT_W-1:0];
    res_next.empty = (count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      res_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      count <= count_next;
      unique case (state)
        ST_IDLE: begin
          if (cmd.seed) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_mask[0]) begin
            state <= ST_PICK;
          end
        end
        ST_PICK: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
      if (res_load) begin
        res_pending <= 1'b1;
      end else if (res_pending && out_free) begin
        res_pending <= 1'b0;
      end
      if (res_pending && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed) begin
      scan_mask <= {1'b1, {(PRIO_W-1){1'b0}}};
    end else if (state == ST_SCAN) begin
      scan_mask <= scan_mask >> 1;
    end
    if (res_load) begin
      res <= res_next;
    end
    if (res_pending && out_free) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.value_out   = out_res.value;
  assign rsp.prio_out    = out_res.prio;
  assign rsp.found       = out_res.found;
  assign rsp.status      = out_res.status;
  assign rsp.entry_count = out_res.count;
  assign rsp.is_empty    = out_res.empty;

  // occupied cells always form the head of the chain, one per counted entry
  `SPQ_ASSERT_IMPLY(a_count_matches, clk, rst, 1'b1, $countones(occupied) == int'(count))
  `SPQ_ASSERT_IMPLY(a_busy_nonempty, clk, rst, state != ST_IDLE, count != '0)
  `SPQ_ASSERT_NEXT(a_pick_done, clk, rst, state == ST_PICK, res_pending && state == ST_IDLE)

endmodule
